// ===== design/drs_pkg.sv =====
package drs_pkg;

    localparam int CAPACITY    = 64;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int NUM_BUCKETS = 256;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int NUM_PASSES  = 8;
    localparam int PASS_W      = $clog2(NUM_PASSES);
    localparam int SWEEP_W     = BKT_W + 1;
    localparam int DATA_W      = 64;

    // element store access: one write port, one read port, two banks
    typedef struct packed {
        logic              wr_en;
        logic              wr_bank;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic              rd_bank;
        logic [ADDR_W-1:0] rd_addr;
    } elem_req_t;

    // bucket count store access
    typedef struct packed {
        logic             wr_en;
        logic [BKT_W-1:0] wr_addr;
        logic [CNT_W-1:0] wr_data;
        logic             rd_en;
        logic [BKT_W-1:0] rd_addr;
    } bkt_req_t;

    // byte of the ordering key selected by the pass number
    function automatic logic [BKT_W-1:0] key_byte(input logic [DATA_W-1:0] v,
                                                  input logic [PASS_W-1:0] pass);
        logic [DATA_W-1:0] k;
        k = v[DATA_W-1] ? ~v : {~v[DATA_W-1], v[DATA_W-2:0]};
        return k[{pass, 3'b000} +: BKT_W];
    endfunction

endpackage

// ===== design/double_radix_sort.sv =====
// Radix sorter for raw 64-bit IEEE-754 double bit patterns.
// Input: present value/last with start; the item is taken at a clock edge
// where start is high and busy is low. While idle, one item is taken per
// cycle. Items beyond 64 held are dropped and remembered as overflow.
// An item with last high (stored or dropped) ends the run: busy rises and
// the block sorts by the ordering key (all bits inverted for negatives,
// sign flipped otherwise), so -0 precedes +0 and NaNs sit at the ends.
// Sorting is eight LSD byte passes over a ping-pong pair of element banks
// and a 256-entry bucket count memory: each pass clears the buckets,
// counts, forms exclusive prefix sums and scatters. Results then stream
// out one per cycle, each marked by a one-cycle result_strobe; final_res
// flags the last item, overflow is high on every result of a run that
// lost items. The receiver cannot stall. Busy falls after the last result.
// Reset clears the control state and the held count; the element stores
// are not cleared.
module double_radix_sort
    import drs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [DATA_W-1:0] value,
    input  logic              last,
    output logic              result_strobe,
    output logic [DATA_W-1:0] sorted_value,
    output logic              final_res,
    output logic              overflow
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_COUNT,
        ST_PREFIX,
        ST_SCATTER,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                drop_reg, drop_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic                ovf_reg, ovf_next;
    logic [PASS_W-1:0]   pass_reg, pass_next;
    logic [SWEEP_W-1:0]  sweep_reg, sweep_next;
    logic [CNT_W-1:0]    acc_reg, acc_next;
    logic                v1_reg, v1_next;
    logic                v2_reg, v2_next;
    logic                lst_reg, lst_next;
    logic [BKT_W-1:0]    k2_reg, k2_next;
    logic [DATA_W-1:0]   d2_reg, d2_next;

    elem_req_t           elem_req;
    logic [DATA_W-1:0]   elem_wr_data;
    logic [DATA_W-1:0]   elem_rd_data;
    bkt_req_t            bkt_req;
    logic [CNT_W-1:0]    bkt_rd_data;

    logic [BKT_W-1:0]    key1;
    logic [SWEEP_W-1:0]  n_ext;
    logic                issue;
    logic [CNT_W-1:0]    cnt_new;
    logic                drop_new;

    drs_elem_mem u_elem_mem (
        .clk     (clk),
        .req     (elem_req),
        .wr_data (elem_wr_data),
        .rd_data (elem_rd_data)
    );

    drs_bucket_mem u_bucket_mem (
        .clk     (clk),
        .req     (bkt_req),
        .rd_data (bkt_rd_data)
    );

    assign key1  = key_byte(elem_rd_data, pass_reg);
    assign n_ext = SWEEP_W'(n_reg);
    assign issue = (sweep_reg < n_ext);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        drop_next    = drop_reg;
        n_next       = n_reg;
        ovf_next     = ovf_reg;
        pass_next    = pass_reg;
        sweep_next   = sweep_reg;
        acc_next     = acc_reg;
        v1_next      = 1'b0;
        v2_next      = 1'b0;
        lst_next     = lst_reg;
        k2_next      = k2_reg;
        d2_next      = d2_reg;
        elem_req     = '0;
        elem_wr_data = value;
        bkt_req      = '0;
        cnt_new      = count_reg;
        drop_new     = drop_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // store the item, or drop it once the store is full
                    if (count_reg < CNT_W'(CAPACITY))
                    begin
                        elem_req.wr_en   = 1'b1;
                        elem_req.wr_bank = 1'b0;
                        elem_req.wr_addr = count_reg[ADDR_W-1:0];
                        cnt_new          = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        drop_new = 1'b1;
                    end
                    count_next = cnt_new;
                    drop_next  = drop_new;
                    if (last)
                    begin
                        n_next     = cnt_new;
                        ovf_next   = drop_new;
                        count_next = '0;
                        drop_next  = 1'b0;
                        pass_next  = '0;
                        sweep_next = '0;
                        state_next = ST_CLEAR;
                    end
                end
            end

            ST_CLEAR:
            begin
                bkt_req.wr_en   = 1'b1;
                bkt_req.wr_addr = sweep_reg[BKT_W-1:0];
                bkt_req.wr_data = '0;
                sweep_next      = sweep_reg + SWEEP_W'(1);
                if (sweep_reg == SWEEP_W'(NUM_BUCKETS - 1))
                begin
                    sweep_next = '0;
                    state_next = ST_COUNT;
                end
            end

            ST_COUNT, ST_SCATTER:
            begin
                // issue: read the source bank
                elem_req.rd_en   = issue;
                elem_req.rd_bank = pass_reg[0];
                elem_req.rd_addr = sweep_reg[ADDR_W-1:0];
                v1_next          = issue;
                // stage 1: look up the bucket of the element just read
                bkt_req.rd_en    = v1_reg;
                bkt_req.rd_addr  = key1;
                v2_next          = v1_reg;
                k2_next          = key1;
                d2_next          = elem_rd_data;
                // stage 2: advance the bucket, place the element on scatter
                bkt_req.wr_en    = v2_reg;
                bkt_req.wr_addr  = k2_reg;
                bkt_req.wr_data  = bkt_rd_data + CNT_W'(1);
                if (state_reg == ST_SCATTER)
                begin
                    elem_req.wr_en   = v2_reg;
                    elem_req.wr_bank = ~pass_reg[0];
                    elem_req.wr_addr = bkt_rd_data[ADDR_W-1:0];
                    elem_wr_data     = d2_reg;
                end
                sweep_next = sweep_reg + SWEEP_W'(1);
                if (sweep_reg == n_ext + SWEEP_W'(1))
                begin
                    sweep_next = '0;
                    if (state_reg == ST_COUNT)
                    begin
                        acc_next   = '0;
                        state_next = ST_PREFIX;
                    end
                    else
                    begin
                        pass_next  = pass_reg + PASS_W'(1);
                        state_next = (pass_reg == PASS_W'(NUM_PASSES - 1)) ? ST_EMIT
                                                                            : ST_CLEAR;
                    end
                end
            end

            ST_PREFIX:
            begin
                // read bucket b while writing the running sum into bucket b-1
                bkt_req.rd_en   = (sweep_reg < SWEEP_W'(NUM_BUCKETS));
                bkt_req.rd_addr = sweep_reg[BKT_W-1:0];
                v1_next         = bkt_req.rd_en;
                k2_next         = sweep_reg[BKT_W-1:0];
                bkt_req.wr_en   = v1_reg;
                bkt_req.wr_addr = k2_reg;
                bkt_req.wr_data = acc_reg;
                if (v1_reg)
                begin
                    acc_next = acc_reg + bkt_rd_data;
                end
                sweep_next = sweep_reg + SWEEP_W'(1);
                if (sweep_reg == SWEEP_W'(NUM_BUCKETS))
                begin
                    sweep_next = '0;
                    state_next = ST_SCATTER;
                end
            end

            ST_EMIT:
            begin
                elem_req.rd_en   = issue;
                elem_req.rd_bank = 1'b0;
                elem_req.rd_addr = sweep_reg[ADDR_W-1:0];
                v1_next          = issue;
                lst_next         = (sweep_reg == n_ext - SWEEP_W'(1));
                sweep_next       = sweep_reg + SWEEP_W'(1);
                if (sweep_reg == n_ext)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            n_reg     <= '0;
            ovf_reg   <= 1'b0;
            pass_reg  <= '0;
            sweep_reg <= '0;
            acc_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            lst_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            n_reg     <= n_next;
            ovf_reg   <= ovf_next;
            pass_reg  <= pass_next;
            sweep_reg <= sweep_next;
            acc_reg   <= acc_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            lst_reg   <= lst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k2_reg <= k2_next;
        d2_reg <= d2_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_strobe = v1_reg && (state_reg == ST_EMIT);
    assign sorted_value  = elem_rd_data;
    assign final_res     = lst_reg;
    assign overflow      = ovf_reg;

endmodule

// ===== design/drs_elem_mem.sv =====
module drs_elem_mem
    import drs_pkg::*;
(
    input  logic              clk,
    input  elem_req_t         req,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] elem_mem_reg    [CAPACITY];
    logic [DATA_W-1:0] scratch_mem_reg [CAPACITY];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en && !req.wr_bank)
        begin
            elem_mem_reg[req.wr_addr] <= wr_data;
        end
        if (req.wr_en && req.wr_bank)
        begin
            scratch_mem_reg[req.wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= req.rd_bank ? scratch_mem_reg[req.rd_addr]
                                       : elem_mem_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/drs_bucket_mem.sv =====
module drs_bucket_mem
    import drs_pkg::*;
(
    input  logic             clk,
    input  bkt_req_t         req,
    output logic [CNT_W-1:0] rd_data
);

    logic [CNT_W-1:0] bkt_mem_reg [NUM_BUCKETS];
    logic [CNT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            bkt_mem_reg[req.wr_addr] <= req.wr_data;
        end
    end

    // write-first: forward a same-cycle write to the same bucket
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            if (req.wr_en && (req.wr_addr == req.rd_addr))
            begin
                rd_data_reg <= req.wr_data;
            end
            else
            begin
                rd_data_reg <= bkt_mem_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== verif/testbench.sv =====
// Predicts the ascending order of each run and checks results against it
class sort_scoreboard;

    typedef struct {
        logic [drs_pkg::DATA_W-1:0] value;
        logic                       final_flag;
        logic                       lost_flag;
    } sorted_item_t;

    logic [drs_pkg::DATA_W-1:0] held_values[$];
    bit                         items_lost;
    sorted_item_t               expected_order[$];
    int                         mismatches;
    int                         results_seen;

    function new();
        items_lost   = 1'b0;
        mismatches   = 0;
        results_seen = 0;
    endfunction

    // Negatives: invert everything; positives: flip the sign only
    function logic [drs_pkg::DATA_W-1:0] numeric_key(logic [drs_pkg::DATA_W-1:0] v);
        return v[drs_pkg::DATA_W-1] ? ~v : {1'b1, v[drs_pkg::DATA_W-2:0]};
    endfunction

    function int pending();
        return expected_order.size();
    endfunction

    function void note_item(logic [drs_pkg::DATA_W-1:0] v, logic is_last);
        logic [drs_pkg::DATA_W-1:0] ordered[$];
        logic [drs_pkg::DATA_W-1:0] cand;
        sorted_item_t               entry;
        int                         j;
        if (held_values.size() < drs_pkg::CAPACITY)
            held_values.insert(held_values.size(), v);
        else
            items_lost = 1'b1;
        if (!is_last)
            return;
        // stable insertion sort; equal keys are identical patterns anyway
        foreach (held_values[i])
        begin
            cand = held_values[i];
            j = ordered.size();
            while (j > 0 && numeric_key(ordered[j-1]) > numeric_key(cand))
                j--;
            ordered.insert(j, cand);
        end
        foreach (ordered[i])
        begin
            entry.value      = ordered[i];
            entry.final_flag = (i == ordered.size() - 1);
            entry.lost_flag  = items_lost;
            expected_order.insert(expected_order.size(), entry);
        end
        held_values.delete();
        items_lost = 1'b0;
    endfunction

    function void check_result(logic [drs_pkg::DATA_W-1:0] v, logic fin, logic ovf);
        sorted_item_t want;
        results_seen++;
        if (expected_order.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: none expected, got value=%h final=%b overflow=%b",
                         results_seen, v, fin, ovf);
            return;
        end
        want = expected_order.pop_front();
        if (want.value !== v || want.final_flag !== fin || want.lost_flag !== ovf)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("result %0d: expected value=%h final=%b overflow=%b,",
                         results_seen, want.value, want.final_flag, want.lost_flag);
                $display("    got value=%h final=%b overflow=%b", v, fin, ovf);
            end
        end
    endfunction

endclass

module testbench;
    import drs_pkg::*;

    localparam int ITEM_TARGET  = 410;
    // worst quiet stretch: eight full passes at capacity plus a long sender gap
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 80;
    localparam int NUM_SPECIALS = 18;

    // signed zeros, infinities, NaNs of both signs, denormals, extremes
    localparam logic [DATA_W-1:0] FP_SPECIALS [0:NUM_SPECIALS-1] = '{
        64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
        64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
        64'h7FF8_0000_0000_0000, 64'hFFF8_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
        64'h0000_0000_0000_0001, 64'h8000_0000_0000_0001,
        64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000,
        64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF,
        64'h7FF0_0000_0000_0001, 64'h0010_0000_0000_0000,
        64'h3FF0_0000_0000_0000, 64'h8000_0000_0000_0000
    };

    logic              clk;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [DATA_W-1:0] value = '0;
    logic              last  = 1'b0;
    logic              busy;
    logic              result_strobe;
    logic [DATA_W-1:0] sorted_value;
    logic              final_res;
    logic              overflow;

    sort_scoreboard    sb;
    int                idle_cycles = 0;
    int                items_sent = 0;
    int                runs_sent = 0;
    int                overflow_runs = 0;
    logic [DATA_W-1:0] run_values[$];

    double_radix_sort i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .value         (value),
        .last          (last),
        .result_strobe (result_strobe),
        .sorted_value  (sorted_value),
        .final_res     (final_res),
        .overflow      (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample both sides at the edge: note accepted items, check strobed results,
    // and track how long nothing has moved
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_item(value, last);
        if (rst_n && result_strobe)
            sb.check_result(sorted_value, final_res, overflow);
        if (rst_n && ((start && !busy) || result_strobe))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Abort the run when neither side has moved for too long
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("stalled for %0d cycles with %0d results outstanding",
                 STALL_LIMIT, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Mostly back-to-back, some short pauses, the odd long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Mix of fully random patterns, specials, extreme exponents, values of +/-1.0
    // that differ only in the low byte, and repeats from the same run
    function automatic logic [DATA_W-1:0] random_double();
        logic [DATA_W-1:0] v;
        int                pick;
        pick = $urandom_range(0, 99);
        v = {$urandom, $urandom};
        if (pick < 10 && run_values.size() > 0)
            return run_values[$urandom_range(0, run_values.size() - 1)];
        if (pick < 25)
            return FP_SPECIALS[$urandom_range(0, NUM_SPECIALS - 1)];
        if (pick < 40)
        begin
            v[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
            return v;
        end
        if (pick < 55)
        begin
            v         = 64'h3FF0_0000_0000_0000;
            v[63]     = 1'($urandom_range(0, 1));
            v[7:0]    = 8'($urandom_range(0, 255));
            return v;
        end
        return v;
    endfunction

    // Present one item and hold it until the block takes it
    task automatic send_item(input logic [DATA_W-1:0] v, input logic is_last,
                             input bit back_to_back);
        int gap;
        gap = back_to_back ? 0 : pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        last  <= is_last;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    task automatic send_run(input int len, input bit back_to_back);
        logic [DATA_W-1:0] v;
        run_values.delete();
        for (int i = 0; i < len; i++)
        begin
            v = random_double();
            run_values.insert(run_values.size(), v);
            send_item(v, i == len - 1, back_to_back);
        end
        runs_sent++;
        if (len > CAPACITY)
            overflow_runs++;
    endtask

    initial
    begin
        int run_idx;
        int len;
        int r;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a lone item forms a run of one
        send_item(64'h0000_0000_0000_0000, 1'b1, 1'b0);
        runs_sent++;

        // Directed: every special pattern in one run, duplicates included
        for (int i = 0; i < NUM_SPECIALS; i++)
            send_item(FP_SPECIALS[i], i == NUM_SPECIALS - 1, 1'b0);
        runs_sent++;

        // Directed: two items arriving in descending order
        send_item(64'h4000_0000_0000_0000, 1'b0, 1'b1);
        send_item(64'hC000_0000_0000_0000, 1'b1, 1'b1);
        runs_sent++;

        // Random runs: mostly short, one exactly full, a few past capacity
        run_idx = 0;
        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (run_idx == 2)
                len = CAPACITY;
            else if (run_idx == 5)
                len = CAPACITY + $urandom_range(1, 6);
            else if (r < 70)
                len = $urandom_range(1, 10);
            else if (r < 92)
                len = $urandom_range(11, 40);
            else if (r < 97)
                len = $urandom_range(41, CAPACITY);
            else
                len = CAPACITY + $urandom_range(1, 4);
            send_run(len, $urandom_range(0, 3) == 0);
            run_idx++;
        end
        start <= 1'b0;
        last  <= 1'b0;

        // Let the monitor note the final item before draining
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items in %0d runs, %0d of them past capacity.",
                 items_sent, runs_sent, overflow_runs);
        $display("Checked %0d sorted results, %0d wrong.", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
